// ----- hw/rtl/sha_pkg.sv -----
// shared types and constants for the sha-256 stream hasher
`default_nettype none
package sha_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic start;
    logic busy;
  } cmp_ctrl_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/sha_if.sv -----
// valid/ready channel interfaces for the hasher
`default_nettype none
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_words_0_1;
  logic [63:0] digest_words_2_3;
  logic [63:0] digest_words_4_5;
  logic [63:0] digest_words_6_7;
  modport source (output valid, digest_words_0_1, digest_words_2_3, digest_words_4_5,
                  digest_words_6_7, input ready);
  modport sink (input valid, digest_words_0_1, digest_words_2_3, digest_words_4_5,
                digest_words_6_7, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sha_round.sv -----
// 64-round compression engine, one round per cycle on a rolling schedule
`default_nettype none
module sha_round (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sha_pkg::cmp_ctrl_t   ctrl_i,
  input  wire logic [511:0]         block_i,
  input  wire logic [255:0]         hash_i,
  output logic [255:0]              hash_o,
  output logic                      done_o
);
  import sha_pkg::*;

  word_t       w_q [16];
  word_t       v_q [8];
  logic [5:0]  rnd_q;
  logic        run_q;
  logic        done_q;

  word_t s0, s1, wn, big1, ch, t1, big0, maj, t2;

  always_comb begin
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn   = w_q[0] + s0 + w_q[9] + s1;
    big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + round_k(rnd_q) + w_q[0];
    big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511-32*i -: 32];
      for (int i = 0; i < 8; i++)  v_q[i] <= hash_i[255-32*i -: 32];
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[255-32*i -: 32] = hash_i[255-32*i -: 32] + v_q[i];
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_core.sv -----
// top level of the sha-256 stream hasher
// usage:
//  - in channel: one request per 32-bit big-endian word; valid_bytes upper
//    bytes count, last_word closes the message
//  - out channel: one request carrying the 256-bit digest per message
//  - a word of n bytes that does not close the message is accepted, absorbed
//    byte by byte, and then the core goes back to idle
//  - the byte that fills a 64-byte block starts a compression in the shared round
//    unit (64 rounds plus the final hash add)
//  - a last word then queues the 0x80 marker, feeds the marker, the zero pad
//    bytes and the 8 length bytes, runs one or two compressions and loads the
//    digest register
//  - in_ready is low while a word is being absorbed or a block compressed
//  - the digest is held in the output register until taken; a new message
//    may start meanwhile, blocking only if a second digest is due
//  - reset restores the initial hash value and clears fill and length
`default_nettype none
module sha256_stream_hasher_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StData, StPad, StLen, StComp, StDone
  } state_e;

  state_e        state_q;
  logic [31:0]   word_q;
  logic [2:0]    cnt_q;       // bytes left of current word
  logic          last_q;
  logic [5:0]    fill_q;
  logic [63:0]   len_q;
  logic [63:0]   plen_q;      // frozen length for padding
  logic [2:0]    lidx_q;      // length byte index
  logic [1:0]    ret_q;       // where to continue after compression
  logic [511:0]  blk_q;
  logic [255:0]  h_q;
  logic          ovalid_q;
  logic [255:0]  dig_q;
  logic          start;
  logic [255:0]  hnew;
  logic          cdone;
  cmp_ctrl_t     ctrl;

  localparam logic [1:0] RetData = 2'd0, RetPad = 2'd1, RetLen = 2'd2, RetFin = 2'd3;

  logic [7:0] byte_v;
  logic       put;

  assign ctrl.start = start;
  assign ctrl.busy  = (state_q == StComp);

  // the byte written on the start edge is merged into the block here
  sha_round u_round (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .block_i({blk_q[511:8], byte_v}), .hash_i(h_q),
    .hash_o(hnew), .done_o(cdone)
  );

  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.digest_words_0_1 = dig_q[255:192];
  assign out_o.digest_words_2_3 = dig_q[191:128];
  assign out_o.digest_words_4_5 = dig_q[127:64];
  assign out_o.digest_words_6_7 = dig_q[63:0];

  always_comb begin
    put = 1'b0;
    byte_v = 8'h00;
    case (state_q)
      StData: begin
        put = (cnt_q != 3'd0);
        byte_v = word_q[31:24];
      end
      StPad: begin
        put = (fill_q != 6'd56);
        byte_v = 8'h00;
      end
      StLen: begin
        put = 1'b1;
        byte_v = plen_q[63 - 8*lidx_q -: 8];
      end
      default: ;
    endcase
  end

  assign start = put && (fill_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      fill_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      lidx_q   <= '0;
      ret_q    <= RetData;
      last_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[255-32*i -: 32] <= init_hash(3'(i));
    end else begin
      // in the done state the output register is reloaded below
      if (out_o.valid && out_o.ready && state_q != StDone) ovalid_q <= 1'b0;
      if (put) fill_q <= fill_q + 6'd1;
      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            state_q <= StData;
            word_q  <= in_i.data_word;
            cnt_q   <= (in_i.valid_bytes > 3'd4) ? 3'd4 : in_i.valid_bytes;
            last_q  <= in_i.last_word;
          end
        end
        StData: begin
          if (cnt_q != 3'd0) begin
            word_q <= {word_q[23:0], 8'h00};
            cnt_q  <= cnt_q - 3'd1;
            len_q  <= len_q + 64'd8;
            // ret_q keeps its value so a marker byte that fills the block
            // still continues with padding
            if (start) begin
              state_q <= StComp;
            end else if (cnt_q == 3'd1 && ret_q == RetPad) begin
              state_q <= StPad;
            end
          end else if (last_q) begin
            // the marker byte is fed through the same byte path
            plen_q  <= len_q;
            word_q  <= 32'h8000_0000;
            cnt_q   <= 3'd1;
            last_q  <= 1'b0;
            state_q <= StData;
            ret_q   <= RetPad;
          end else if (ret_q == RetPad) begin
            state_q <= StPad;
          end else begin
            state_q <= StIdle;
          end
        end
        StPad: begin
          if (fill_q == 6'd56) begin
            state_q <= StLen;
            lidx_q  <= '0;
          end else if (start) begin
            state_q <= StComp;
          end
        end
        StLen: begin
          lidx_q <= lidx_q + 3'd1;
          if (start) begin
            state_q <= StComp;
            ret_q   <= RetFin;
          end
        end
        StComp: begin
          if (cdone) begin
            h_q <= hnew;
            case (ret_q)
              RetData: state_q <= (cnt_q == 3'd0 && !last_q) ? StIdle : StData;
              RetPad:  state_q <= (cnt_q == 3'd0) ? StPad : StData;
              RetLen:  state_q <= StLen;
              default: state_q <= StDone;
            endcase
          end
        end
        StDone: begin
          if (!ovalid_q || out_o.ready) begin
            dig_q    <= h_q;
            ovalid_q <= 1'b1;
            len_q    <= '0;
            fill_q   <= '0;
            ret_q    <= RetData;
            for (int i = 0; i < 8; i++) h_q[255-32*i -: 32] <= init_hash(3'(i));
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // byte lane write into the block buffer
  always_ff @(posedge clk_i) begin
    if (put) blk_q[511 - 8*fill_q -: 8] <= byte_v;
  end
endmodule
`default_nettype wire
